// ===== src/pcme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pcme_pkg;

   typedef enum logic [1:0] {
      FUNC_WEIGHT  = 2'd0,
      FUNC_BIAS    = 2'd1,
      FUNC_FEATURE = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [5:0]         out_index;
      logic [5:0]         in_index;
      logic signed [15:0] sample;
      logic signed [31:0] bias_word;
   } req_type;

   typedef struct packed {
      logic [5:0]         out_channel;
      logic [15:0]        pixel_index;
      logic signed [31:0] out_value;
      logic               last;
   } rsp_type;

   localparam logic [1:0] REG_IN_CH  = 2'd0;
   localparam logic [1:0] REG_OUT_CH = 2'd1;
   localparam logic [1:0] REG_PIXELS = 2'd2;

   localparam int ACC_W = 48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ===== src/pcme_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pcme_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_push,
   output logic              req_full,
   input  pcme_pkg::req_type req_word,
   output logic              q_valid,
   output pcme_pkg::req_type q_word,
   input  wire               q_take
);
   import pcme_pkg::*;

   // two-entry queue; drop unused func codes at the door
   req_type  mem_ff [2];
   logic     wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic     wr, rd;

   assign req_full = (cnt_ff == 2'd2);
   assign wr = req_push && !req_full && (req_word.func != FUNC_NONE);
   assign rd = q_take && (cnt_ff != 2'd0);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_word = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ wr;
      rp_in = rp_ff ^ rd;
      cnt_in = cnt_ff + {1'b0, wr} - {1'b0, rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr) mem_ff[wp_ff] <= req_word;
   end
endmodule
`default_nettype wire

// ===== src/pcme_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pcme_back #(
   parameter int MAX_IN_CH  = 64,
   parameter int MAX_OUT_CH = 64
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               q_valid,
   input  pcme_pkg::req_type q_word,
   output logic              q_take,
   input  wire [6:0]         in_ch,
   input  wire [6:0]         out_ch,
   input  wire [16:0]        pixels,
   output logic              rsp_empty,
   input  wire               rsp_pop,
   output pcme_pkg::rsp_type rsp_word
);
   import pcme_pkg::*;

   localparam int IW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
   localparam int OW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
   localparam int CW = $clog2(MAX_IN_CH + 1) + 1;
   localparam int NW = $clog2(MAX_OUT_CH + 1);

   logic signed [15:0]    wmem [MAX_OUT_CH * MAX_IN_CH];
   logic signed [31:0]    bmem [MAX_OUT_CH];
   logic signed [ACC_W-1:0] amem [MAX_OUT_CH];
   logic [MAX_OUT_CH-1:0] acc_vld_ff;   // accumulator written since reset

   state_type st_ff, st_in;
   logic [CW-1:0] ch_ff, ch_in;
   logic [15:0]   pix_ff, pix_in;
   logic [OW:0]   o_ff, o_in;      // issue index
   logic          p1_ff, p1_in;    // read stage valid
   logic [OW-1:0] p1o_ff;
   logic          p1last_ff;
   logic          first_ff, emitting_ff;
   logic signed [15:0] feat_ff;
   logic signed [15:0] wrd_ff;
   logic signed [31:0] brd_ff;
   logic signed [ACC_W-1:0] ard_ff;
   logic          p2_ff;
   logic [OW-1:0] p2o_ff;
   logic          p2last_ff, p2emit_ff, p2first_ff;
   logic signed [31:0] p2b_ff;
   logic signed [ACC_W-1:0] p2a_ff;
   logic signed [31:0] prod_ff;
   rsp_type       out_ff;
   logic          full_ff;

   logic [NW-1:0] nout;
   logic [CW-1:0] nin;
   logic [16:0]   npix;
   logic [CW-1:0] chsel;
   logic          issue_done, pipe_idle, done_pix;

   always_comb begin
      nout = (out_ch == 7'd0) ? NW'(1) :
             ({25'd0, out_ch} > MAX_OUT_CH) ? NW'(MAX_OUT_CH) : NW'(out_ch);
      nin  = (in_ch == 7'd0) ? CW'(1) :
             ({25'd0, in_ch} > MAX_IN_CH) ? CW'(MAX_IN_CH) : CW'(in_ch);
      npix = (pixels == 17'd0) ? 17'd1 : (pixels > 17'h10000) ? 17'h10000 : pixels;
      chsel = (ch_ff >= CW'(MAX_IN_CH)) ? CW'(MAX_IN_CH - 1) : ch_ff;
      issue_done = ({{(NW > OW + 1 ? NW - OW - 1 : 0){1'b0}}, o_ff} >= (OW + 1)'(nout));
      pipe_idle = !p1_ff && !p2_ff;
      done_pix = (ch_ff + CW'(1) >= nin);
   end

   wire can_emit = !full_ff || rsp_pop;
   assign q_take = (st_ff == ST_IDLE) && q_valid;
   wire start_mac = q_take && (q_word.func == FUNC_FEATURE);
   wire issue = (st_ff == ST_MAC) || ((st_ff == ST_EMIT) && can_emit && !p1_ff && !p2_ff);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (start_mac) st_in = ST_MAC;
         ST_MAC:  if (issue_done && pipe_idle) st_in = done_pix ? ST_EMIT : ST_IDLE;
                  else st_in = ST_MAC;
         ST_EMIT: if (issue_done && pipe_idle) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      o_in = o_ff;
      p1_in = 1'b0;
      ch_in = ch_ff;
      pix_in = pix_ff;
      if (start_mac) o_in = '0;
      else if ((st_ff == ST_MAC) && !issue_done) begin
         o_in = o_ff + 1'b1;
         p1_in = 1'b1;
      end else if ((st_ff == ST_MAC) && pipe_idle) begin
         o_in = '0;
         if (!done_pix) ch_in = ch_ff + CW'(1);
      end else if ((st_ff == ST_EMIT) && issue && !issue_done) begin
         o_in = o_ff + 1'b1;
         p1_in = 1'b1;
      end else if ((st_ff == ST_EMIT) && issue_done && pipe_idle) begin
         ch_in = '0;
         pix_in = ({1'b0, pix_ff} + 17'd1 >= npix) ? 16'd0 : pix_ff + 16'd1;
      end
   end

   // loads and stage one: read stores
   always_ff @(posedge clock) begin
      if (q_take && q_word.func == FUNC_WEIGHT &&
          {26'd0, q_word.out_index} < MAX_OUT_CH && {26'd0, q_word.in_index} < MAX_IN_CH)
         wmem[(OW + IW)'(q_word.out_index) * (OW + IW)'(MAX_IN_CH)
              + (OW + IW)'(q_word.in_index)] <= q_word.sample;
      if (q_take && q_word.func == FUNC_BIAS && {26'd0, q_word.out_index} < MAX_OUT_CH)
         bmem[OW'(q_word.out_index)] <= q_word.bias_word;
      if (start_mac) feat_ff <= q_word.sample;
      if (start_mac) first_ff <= (ch_ff == '0);
      if (start_mac) emitting_ff <= 1'b0;
      if (st_ff == ST_MAC && issue_done && pipe_idle) emitting_ff <= done_pix;
      if (p1_in) begin
         wrd_ff <= wmem[(OW + IW)'(o_ff[OW-1:0]) * (OW + IW)'(MAX_IN_CH)
                        + (OW + IW)'(chsel)];
         brd_ff <= bmem[o_ff[OW-1:0]];
         ard_ff <= acc_vld_ff[o_ff[OW-1:0]] ? amem[o_ff[OW-1:0]] : '0;
         p1o_ff <= o_ff[OW-1:0];
         p1last_ff <= ((OW + 1)'(o_ff) + 1'b1 == (OW + 1)'(nout));
      end
      // stage two: multiply
      if (p1_ff) begin
         prod_ff <= wrd_ff * feat_ff;
         p2o_ff <= p1o_ff;
         p2last_ff <= p1last_ff;
         p2emit_ff <= emitting_ff;
         p2first_ff <= first_ff;
         p2b_ff <= brd_ff;
         p2a_ff <= ard_ff;
      end
      // stage three: accumulate or emit
      if (p2_ff && !p2emit_ff)
         amem[p2o_ff] <= (p2first_ff ? ACC_W'(p2b_ff) : p2a_ff) + ACC_W'(prod_ff);
      if (p2_ff && p2emit_ff) begin
         out_ff.out_channel <= 6'(p2o_ff);
         out_ff.pixel_index <= pix_ff;
         out_ff.last <= p2last_ff;
         out_ff.out_value <= (p2a_ff > ACC_W'(32'sh7fffffff)) ? 32'sh7fffffff :
                             (p2a_ff < -ACC_W'(33'sh80000000)) ? 32'sh80000000 :
                             32'(p2a_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ch_ff <= '0;
         pix_ff <= '0;
         o_ff <= '0;
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
         full_ff <= 1'b0;
         acc_vld_ff <= '0;
      end else begin
         st_ff <= st_in;
         ch_ff <= ch_in;
         pix_ff <= pix_in;
         o_ff <= o_in;
         p1_ff <= p1_in;
         p2_ff <= p1_ff;
         if (p2_ff && !p2emit_ff) acc_vld_ff[p2o_ff] <= 1'b1;
         if (p2_ff && p2emit_ff) full_ff <= 1'b1;
         else if (rsp_pop) full_ff <= 1'b0;
      end
   end

   assign rsp_empty = !full_ff;
   assign rsp_word = out_ff;
endmodule
`default_nettype wire

// ===== src/pointwise_conv_mac_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 1x1 convolution with bias in fixed point. Weight and bias loads are written
// to their stores as they are taken from the two-word input queue. A feature
// word walks every active output channel through one shared multiply-accumulate
// pipeline (read, multiply, add). The last input channel of a pixel adds an emit
// pass of output_channels results, one result at a time, since each waits for the
// pipeline to drain and for the single output register to be taken. Accumulators
// start from zero after reset.
module pointwise_conv_mac_engine #(
   parameter int MAX_IN_CH  = 64,
   parameter int MAX_OUT_CH = 64
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_push,
   output logic              req_full,
   input  pcme_pkg::req_type req_word,
   output logic              rsp_empty,
   input  wire               rsp_pop,
   output pcme_pkg::rsp_type rsp_word,
   input  wire               csr_psel,
   input  wire               csr_penable,
   input  wire               csr_pwrite,
   input  wire [3:0]         csr_paddr,
   input  wire [31:0]        csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import pcme_pkg::*;

   logic [6:0]  in_ch_ff, out_ch_ff;
   logic [16:0] pix_ff;
   logic        q_valid, q_take;
   req_type     q_word;

   assign csr_pready = 1'b1;
   wire wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff <= 7'd1;
         out_ch_ff <= 7'd1;
         pix_ff <= 17'd1;
      end else if (wr) begin
         unique case (csr_paddr[3:2])
            REG_IN_CH:  in_ch_ff <= csr_pwdata[6:0];
            REG_OUT_CH: out_ch_ff <= csr_pwdata[6:0];
            REG_PIXELS: pix_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_IN_CH:  csr_prdata = {25'd0, in_ch_ff};
         REG_OUT_CH: csr_prdata = {25'd0, out_ch_ff};
         REG_PIXELS: csr_prdata = {15'd0, pix_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   pcme_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_word(req_word), .q_valid(q_valid), .q_word(q_word), .q_take(q_take)
   );

   pcme_back #(.MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_word(q_word),
      .q_take(q_take), .in_ch(in_ch_ff), .out_ch(out_ch_ff), .pixels(pix_ff),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word)
   );
endmodule
`default_nettype wire

// ===== tb/sv/tb_pointwise_conv_mac_engine.sv =====
`timescale 1ns / 1ps
module tb_pointwise_conv_mac_engine;
   import pcme_pkg::*;

   localparam int NCH = 64;
   localparam int STALL_LIMIT = 6000;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type result;
   } dir_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   req_type     req_word = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_word;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pointwise_conv_mac_engine uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_word(req_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // conv state mirror
   logic signed [15:0] weight_mem [NCH][NCH];
   logic signed [31:0] bias_mem [NCH];
   bit                 weight_set [NCH][NCH];
   bit                 bias_set [NCH];
   longint             acc_mem [NCH];
   int                 chan_cnt;
   int                 pix_cnt;
   int                 eff_in, eff_out, eff_pix;
   rsp_type            conv_results [$];

   int  errors = 0;
   int  idle_cycles = 0;
   bit  hold_receiver = 1'b0;
   bit  sender_no_gap = 1'b0;

   function automatic int clamp_cfg(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void apply_word(req_type w);
      int     ch;
      longint v;
      rsp_type r;
      case (w.func)
         FUNC_WEIGHT: begin
            weight_mem[w.out_index][w.in_index] = w.sample;
            weight_set[w.out_index][w.in_index] = 1'b1;
         end
         FUNC_BIAS: begin
            bias_mem[w.out_index] = w.bias_word;
            bias_set[w.out_index] = 1'b1;
         end
         FUNC_FEATURE: begin
            ch = (chan_cnt >= NCH) ? NCH - 1 : chan_cnt;
            for (int o = 0; o < eff_out; o++) begin
               if (chan_cnt == 0) acc_mem[o] = longint'(bias_mem[o]);
               acc_mem[o] += longint'(weight_mem[o][ch]) * longint'(w.sample);
            end
            if (chan_cnt + 1 < eff_in) begin
               chan_cnt = (chan_cnt + 1) & 8'h7F;
            end else begin
               for (int o = 0; o < eff_out; o++) begin
                  v = acc_mem[o];
                  if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
                  if (v < -64'sh80000000) v = -64'sh80000000;
                  r.out_channel = o[5:0];
                  r.pixel_index = pix_cnt[15:0];
                  r.out_value = v[31:0];
                  r.last = (o + 1 == eff_out);
                  conv_results.push_back(r);
               end
               chan_cnt = 0;
               pix_cnt = (pix_cnt + 1 >= eff_pix) ? 0 : pix_cnt + 1;
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_psel && csr_penable)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("tb_pointwise_conv_mac_engine: errors");
         $finish;
      end
   end

   // entered just after a rising edge (or at start); leaves just after acceptance
   task automatic push_word(req_type w, bit typed, rsp_type t);
      int gap;
      gap = sender_no_gap ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_full);
      apply_word(w);
      if (typed) begin
         void'(conv_results.pop_back());
         conv_results.push_back(t);
      end
   endtask

   task automatic send_plain(req_type w);
      push_word(w, 1'b0, '0);
   endtask

   // load any store entry the next feature would read before it was written
   task automatic cover_feature_reads();
      req_type w;
      int ch;
      ch = (chan_cnt >= NCH) ? NCH - 1 : chan_cnt;
      for (int o = 0; o < eff_out; o++) begin
         if (!weight_set[o][ch]) begin
            w = req_type'({$urandom, $urandom});
            w.func = FUNC_WEIGHT;
            w.out_index = o[5:0];
            w.in_index = ch[5:0];
            send_plain(w);
         end
         if (chan_cnt == 0 && !bias_set[o]) begin
            w = req_type'({$urandom, $urandom});
            w.func = FUNC_BIAS;
            w.out_index = o[5:0];
            send_plain(w);
         end
      end
   endtask

   // wait out results and any feature words still in the queue and the pipeline
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (conv_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_IN_CH:  eff_in = clamp_cfg(data & 32'h7F, NCH);
         REG_OUT_CH: eff_out = clamp_cfg(data & 32'h7F, NCH);
         REG_PIXELS: eff_pix = clamp_cfg(data & 32'h1FFFF, 65536);
         default: ;
      endcase
   endtask

   task automatic random_run(int n);
      req_type w;
      int pick;
      for (int k = 0; k < n; k++) begin
         w = req_type'({$urandom, $urandom});
         pick = $urandom_range(0, 99);
         if (pick < 70) w.func = FUNC_FEATURE;
         else if (pick < 84) w.func = FUNC_WEIGHT;
         else if (pick < 95) w.func = FUNC_BIAS;
         else w.func = FUNC_NONE;
         if (w.func == FUNC_FEATURE) cover_feature_reads();
         send_plain(w);
      end
   endtask

   // result side
   initial begin
      int stall;
      rsp_type want;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_receiver) begin
            stall = 500;
            hold_receiver = 1'b0;
         end else begin
            stall = sender_no_gap ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (conv_results.size() == 0) begin
            $error("result word with nothing expected: %p", rsp_word);
            errors++;
         end else begin
            want = conv_results.pop_front();
            if (rsp_word.out_channel !== want.out_channel) begin
               $error("out_channel: expected %0d, got %0d",
                      want.out_channel, rsp_word.out_channel);
               errors++;
            end
            if (rsp_word.pixel_index !== want.pixel_index) begin
               $error("pixel_index: expected %0d, got %0d",
                      want.pixel_index, rsp_word.pixel_index);
               errors++;
            end
            if (rsp_word.out_value !== want.out_value) begin
               $error("out_value: expected %h, got %h", want.out_value, rsp_word.out_value);
               errors++;
            end
            if (rsp_word.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_word.last);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   dir_row_t dir_tab [14];
   int       phase_cfg [8][3];

   initial begin
      dir_tab = '{
         '{'{FUNC_WEIGHT, 6'd0, 6'd0, 16'sh7FFF, 32'sd0}, 1'b0, '0},
         '{'{FUNC_BIAS, 6'd0, 6'd0, 16'sd0, 32'sh7FFFFFFF}, 1'b0, '0},
         '{'{FUNC_FEATURE, 6'd0, 6'd0, 16'sh7FFF, 32'sd0}, 1'b1,
           '{6'd0, 16'd0, 32'sh7FFFFFFF, 1'b1}},
         '{'{FUNC_BIAS, 6'd0, 6'd0, 16'sd0, 32'sh80000000}, 1'b0, '0},
         '{'{FUNC_WEIGHT, 6'd0, 6'd0, 16'sh8000, 32'sd0}, 1'b0, '0},
         '{'{FUNC_FEATURE, 6'd0, 6'd0, 16'sh7FFF, 32'sd0}, 1'b1,
           '{6'd0, 16'd0, 32'sh80000000, 1'b1}},
         '{'{FUNC_FEATURE, 6'd0, 6'd0, 16'sh8000, 32'sd0}, 1'b1,
           '{6'd0, 16'd0, 32'shC0000000, 1'b1}},
         '{'{FUNC_WEIGHT, 6'd63, 6'd63, 16'sh1234, 32'sd0}, 1'b0, '0},
         '{'{FUNC_BIAS, 6'd63, 6'd0, 16'sd0, 32'sd0}, 1'b0, '0},
         '{'{FUNC_NONE, 6'd63, 6'd63, 16'shFFFF, 32'shFFFFFFFF}, 1'b0, '0},
         '{'{FUNC_BIAS, 6'd0, 6'd0, 16'sd0, 32'sd0}, 1'b0, '0},
         '{'{FUNC_WEIGHT, 6'd0, 6'd0, 16'sh0100, 32'sd0}, 1'b0, '0},
         '{'{FUNC_FEATURE, 6'd0, 6'd0, 16'sh0100, 32'sd0}, 1'b1,
           '{6'd0, 16'd0, 32'sh00010000, 1'b1}},
         '{'{FUNC_FEATURE, 6'd0, 6'd0, 16'shFFFF, 32'sd0}, 1'b1,
           '{6'd0, 16'd0, 32'shFFFFFF00, 1'b1}}
      };
      phase_cfg = '{
         '{8, 8, 3}, '{3, 5, 4}, '{0, 0, 0}, '{127, 2, 32'h1FFFF},
         '{1, 64, 2}, '{2, 1, 1}, '{5, 3, 7}, '{1, 1, 1}
      };
      for (int o = 0; o < NCH; o++) begin
         acc_mem[o] = 0;
         bias_set[o] = 1'b0;
         for (int i = 0; i < NCH; i++) weight_set[o][i] = 1'b0;
      end
      chan_cnt = 0;
      pix_cnt = 0;
      eff_in = 1;
      eff_out = 1;
      eff_pix = 1;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[r]) push_word(dir_tab[r].word, dir_tab[r].typed, dir_tab[r].result);

      for (int p = 0; p < 8; p++) begin
         settle();
         csr_write(REG_IN_CH, phase_cfg[p][0]);
         csr_write(REG_OUT_CH, phase_cfg[p][1]);
         csr_write(REG_PIXELS, phase_cfg[p][2]);
         @(posedge clock);
         sender_no_gap = (p == 4);
         if (p == 1) hold_receiver = 1'b1;
         if (p == 0) begin
            random_run(40);
         end else begin
            random_run(15);
            if (p == 2) begin
               // let the block drain completely before going on
               @(negedge clock);
               req_push <= 1'b0;
               while (conv_results.size() != 0) @(posedge clock);
            end
            random_run(15);
         end
      end
      // random settings, written mid-pixel as it falls
      for (int p = 0; p < 4; p++) begin
         settle();
         csr_write(REG_IN_CH, $urandom_range(1, 8));
         csr_write(REG_OUT_CH, $urandom_range(1, 8));
         csr_write(REG_PIXELS, $urandom_range(1, 9));
         @(posedge clock);
         random_run(20);
      end

      settle();
      if (errors == 0) begin
         $display("tb_pointwise_conv_mac_engine: clean");
      end else begin
         $display("tb_pointwise_conv_mac_engine: errors");
      end
      $finish;
   end

endmodule
